### hdl/dqb_pkg.sv
// ----------------------------------------------------------------------------
// dqb_pkg
// shared types and constants of the dns query builder
// ----------------------------------------------------------------------------
package dqb_pkg;

  localparam int unsigned MaxLabelDef = 32;

  localparam logic [7:0] DotChar = 8'd46;

  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned TailBytes = 5;
  localparam int unsigned CntW      = 4;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegTransactionId = 8'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderFlags   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegQueryType     = 8'd2;
  localparam logic [CfgIdxW-1:0] RegQueryClass    = 8'd3;

  localparam logic [15:0] TransactionIdRst = 16'h0000;
  localparam logic [15:0] HeaderFlagsRst   = 16'h0180;
  localparam logic [15:0] QueryTypeRst     = 16'h0001;
  localparam logic [15:0] QueryClassRst    = 16'h0001;
  localparam logic [15:0] QdCount          = 16'h0001;

  typedef struct packed {
    logic [15:0] transaction_id;
    logic [15:0] header_flags;
    logic [15:0] query_type;
    logic [15:0] query_class;
  } cfg_t;

endpackage

### hdl/dqb_label_ram.sv
// ----------------------------------------------------------------------------
// dqb_label_ram
// label character store, one write and one registered read port
// ----------------------------------------------------------------------------
module dqb_label_ram #(
  parameter int unsigned Depth = dqb_pkg::MaxLabelDef,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/dqb_cfg_regs.sv
// ----------------------------------------------------------------------------
// dqb_cfg_regs
// header and question configuration registers
// ----------------------------------------------------------------------------
module dqb_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dqb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dqb_pkg::CfgDataW-1:0] cfg_data_i,
  output dqb_pkg::cfg_t                cfg_o
);

  dqb_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.transaction_id <= dqb_pkg::TransactionIdRst;
      cfg_q.header_flags   <= dqb_pkg::HeaderFlagsRst;
      cfg_q.query_type     <= dqb_pkg::QueryTypeRst;
      cfg_q.query_class    <= dqb_pkg::QueryClassRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dqb_pkg::RegTransactionId: cfg_q.transaction_id <= cfg_data_i;
        dqb_pkg::RegHeaderFlags:   cfg_q.header_flags   <= cfg_data_i;
        dqb_pkg::RegQueryType:     cfg_q.query_type     <= cfg_data_i;
        dqb_pkg::RegQueryClass:    cfg_q.query_class    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/dqb_ctrl.sv
// ----------------------------------------------------------------------------
// dqb_ctrl
// packet sequencer: header, label flush from the store, question tail
// ----------------------------------------------------------------------------
module dqb_ctrl #(
  parameter int unsigned MaxLabel = dqb_pkg::MaxLabelDef,
  parameter int unsigned IdxW     = 5,
  parameter int unsigned LenW     = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqb_pkg::cfg_t       cfg_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_char_i,
  input  logic                in_end_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_end_o,
  output logic                out_ovf_o,
  // label store
  output logic                ram_we_o,
  output logic [IdxW-1:0]     ram_waddr_o,
  output logic [7:0]          ram_wdata_o,
  output logic [IdxW-1:0]     ram_raddr_o,
  input  logic [7:0]          ram_rdata_i
);

  typedef enum logic [2:0] {
    StIdle,
    StHdr,
    StLen,
    StLbl,
    StTail
  } state_e;

  state_e                   state_q, state_d;
  logic [dqb_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [LenW-1:0]          len_q, len_d;
  logic [LenW-1:0]          flen_q, flen_d;
  logic                     hdr_sent_q, hdr_sent_d;
  logic                     ovf_q, ovf_d;
  logic                     end_q, end_d;
  logic                     flush_q, flush_d;
  logic                     ovalid_q, ovalid_d;
  logic [7:0]               obyte_q, obyte_d;
  logic                     oend_q, oend_d;
  logic                     oovf_q, oovf_d;

  logic                     take;
  logic                     slot_free;
  logic                     is_dot;
  logic                     room;
  logic [7:0]               hdr_byte;
  logic [7:0]               tail_byte;

  assign in_ready_o = (state_q == StIdle);
  assign take       = in_valid_i && in_ready_o;
  assign slot_free  = !ovalid_q || out_ready_i;
  assign is_dot     = (in_char_i == dqb_pkg::DotChar);
  assign room       = (len_q < LenW'(MaxLabel));

  assign ram_we_o    = take && !is_dot && room;
  assign ram_waddr_o = len_q[IdxW-1:0];
  assign ram_wdata_o = in_char_i;
  // read address follows the next index so that read data matches idx_q
  assign ram_raddr_o = idx_d;

  always_comb begin
    case (cnt_q)
      4'd0:    hdr_byte = cfg_i.transaction_id[15:8];
      4'd1:    hdr_byte = cfg_i.transaction_id[7:0];
      4'd2:    hdr_byte = cfg_i.header_flags[15:8];
      4'd3:    hdr_byte = cfg_i.header_flags[7:0];
      4'd4:    hdr_byte = dqb_pkg::QdCount[15:8];
      4'd5:    hdr_byte = dqb_pkg::QdCount[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cnt_q)
      4'd1:    tail_byte = cfg_i.query_type[15:8];
      4'd2:    tail_byte = cfg_i.query_type[7:0];
      4'd3:    tail_byte = cfg_i.query_class[15:8];
      4'd4:    tail_byte = cfg_i.query_class[7:0];
      default: tail_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    len_d      = len_q;
    flen_d     = flen_q;
    hdr_sent_d = hdr_sent_q;
    ovf_d      = ovf_q;
    end_d      = end_q;
    flush_d    = flush_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    obyte_d    = obyte_q;
    oend_d     = oend_q;
    oovf_d     = oovf_q;

    case (state_q)
      StIdle: begin
        if (take) begin
          end_d   = in_end_i;
          flush_d = is_dot || in_end_i;
          cnt_d   = '0;
          idx_d   = '0;
          if (!is_dot) begin
            if (room) begin
              len_d = len_q + LenW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (!hdr_sent_q) begin
            state_d = StHdr;
          end else if (is_dot || in_end_i) begin
            state_d = StLen;
          end
        end
      end
      StHdr: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          obyte_d  = hdr_byte;
          oend_d   = 1'b0;
          oovf_d   = ovf_q;
          if (cnt_q == dqb_pkg::CntW'(dqb_pkg::HdrBytes - 1)) begin
            cnt_d      = '0;
            hdr_sent_d = 1'b1;
            state_d    = flush_q ? StLen : StIdle;
          end else begin
            cnt_d = cnt_q + dqb_pkg::CntW'(1);
          end
        end
      end
      StLen: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          obyte_d  = 8'(len_q);
          oend_d   = 1'b0;
          oovf_d   = ovf_q;
          flen_d   = len_q;
          len_d    = '0;
          if (len_q != '0) begin
            state_d = StLbl;
          end else begin
            state_d = end_q ? StTail : StIdle;
          end
        end
      end
      StLbl: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          obyte_d  = ram_rdata_i;
          oend_d   = 1'b0;
          oovf_d   = ovf_q;
          if (LenW'(idx_q) == flen_q - LenW'(1)) begin
            idx_d   = '0;
            state_d = end_q ? StTail : StIdle;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      StTail: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          obyte_d  = tail_byte;
          oovf_d   = ovf_q;
          if (cnt_q == dqb_pkg::CntW'(dqb_pkg::TailBytes - 1)) begin
            oend_d     = 1'b1;
            cnt_d      = '0;
            hdr_sent_d = 1'b0;
            ovf_d      = 1'b0;
            len_d      = '0;
            state_d    = StIdle;
          end else begin
            oend_d = 1'b0;
            cnt_d  = cnt_q + dqb_pkg::CntW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      idx_q      <= '0;
      len_q      <= '0;
      flen_q     <= '0;
      hdr_sent_q <= 1'b0;
      ovf_q      <= 1'b0;
      end_q      <= 1'b0;
      flush_q    <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      len_q      <= len_d;
      flen_q     <= flen_d;
      hdr_sent_q <= hdr_sent_d;
      ovf_q      <= ovf_d;
      end_q      <= end_d;
      flush_q    <= flush_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    oend_q  <= oend_d;
    oovf_q  <= oovf_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_end_o   = oend_q;
  assign out_ovf_o   = oovf_q;

endmodule

### hdl/dns_query_builder_core.sv
// ----------------------------------------------------------------------------
// dns_query_builder_core
// builds a dns query packet from a domain name streamed in per character
// ----------------------------------------------------------------------------
// the slave stream takes one name character per transaction, tlast on the
// final character. the master stream gives the packet one byte per
// transaction, tlast on the last byte, tuser set once a label of the
// packet was cut to MAX_LABEL characters. the config channel writes the
// transaction id, flag word, query type and class; it is always ready.
// the first character of a name first sends the 12 header bytes; a plain
// character sends nothing. a dot or the final character flushes the label
// from the store at one byte per cycle while the master side takes them: a
// length byte, then the label bytes, and the final character adds 5
// question-tail bytes. the store is read at the next index, so no bubbles.
// one character is worked on at a time; s_axis_tready is high only when
// the sequencer is idle. a stalled master side holds the output register
// and freezes the sequencer. reset closes any open packet, drops the
// current label and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dns_query_builder_core #(
  parameter int unsigned MAX_LABEL = dqb_pkg::MaxLabelDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // name_char
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,
  input  logic                         s_axis_tlast,
  // packet_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,
  output logic                         m_axis_tlast,
  // label_overflow
  output logic                         m_axis_tuser,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dqb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dqb_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int unsigned LenW = $clog2(MAX_LABEL + 1);

  dqb_pkg::cfg_t   cfg;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [7:0]      ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [7:0]      ram_rdata;

  dqb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dqb_label_ram #(
    .Depth (MAX_LABEL),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dqb_ctrl #(
    .MaxLabel (MAX_LABEL),
    .IdxW     (IdxW),
    .LenW     (LenW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_end_o   (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

### dv/dqb_stream_checker.sv
// ----------------------------------------------------------------------------
// dqb_stream_checker
// predicts the query packet bytes and compares them with the master stream
// ----------------------------------------------------------------------------
// Watches the name stream, the packet stream and the config channel.
// Every accepted name character is turned into the packet bytes it must
// cause. The bytes are held in order and compared against each byte the
// block hands out, field by field. Extra and wrong bytes are counted as
// failures; bytes still expected are reported as pending.
// ----------------------------------------------------------------------------
module dqb_stream_checker #(
  parameter int unsigned MAX_LABEL = dqb_pkg::MaxLabelDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         s_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [7:0]                   m_tdata_i,
  input  logic                         m_tlast_i,
  input  logic                         m_tuser_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [dqb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dqb_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import dqb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } pkt_byte_t;

  pkt_byte_t   expected_bytes[$];
  cfg_t        regs;
  logic        packet_open = 1'b0;
  logic [7:0]  label_buf [MAX_LABEL];
  int unsigned label_len = 0;
  logic        ovf_seen = 1'b0;
  int          fails = 0;
  int          pending = 0;

  assign pending_o    = pending;
  assign fail_count_o = fails;

  function automatic void push_byte(logic [7:0] b, logic last);
    expected_bytes.push_back(pkt_byte_t'{data: b, last: last, ovf: ovf_seen});
  endfunction

  function automatic void push_word(logic [15:0] w, logic last);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], last);
  endfunction

  function automatic void predict_packet_bytes(logic [7:0] ch, logic name_end);
    if (!packet_open) begin
      push_word(regs.transaction_id, 1'b0);
      push_word(regs.header_flags, 1'b0);
      push_word(QdCount, 1'b0);
      repeat (3) push_word(16'h0000, 1'b0);
      packet_open = 1'b1;
    end
    if (ch != DotChar) begin
      if (label_len < MAX_LABEL) begin
        label_buf[label_len] = ch;
        label_len++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    if (ch == DotChar || name_end) begin
      push_byte(8'(label_len), 1'b0);
      for (int i = 0; i < label_len; i++) push_byte(label_buf[i], 1'b0);
      label_len = 0;
    end
    if (name_end) begin
      // root terminator, then type and class
      push_byte(8'h00, 1'b0);
      push_word(regs.query_type, 1'b0);
      push_word(regs.query_class, 1'b1);
      packet_open = 1'b0;
      label_len   = 0;
      ovf_seen    = 1'b0;
    end
  endfunction

  function automatic void check_packet_byte(logic [7:0] data, logic last, logic ovf);
    pkt_byte_t want;
    if (expected_bytes.size() == 0) begin
      $error("packet byte %0h arrived with no byte expected", data);
      fails++;
    end else begin
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("packet_byte: expected %0h, actual %0h", want.data, data);
        fails++;
      end
      if (last !== want.last) begin
        $error("packet_end: expected %0b, actual %0b", want.last, last);
        fails++;
      end
      if (ovf !== want.ovf) begin
        $error("label_overflow: expected %0b, actual %0b", want.ovf, ovf);
        fails++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs        = '{TransactionIdRst, HeaderFlagsRst, QueryTypeRst, QueryClassRst};
      packet_open = 1'b0;
      label_len   = 0;
      ovf_seen    = 1'b0;
      expected_bytes.delete();
      pending     = 0;
    end else begin
      // a byte leaving now belongs to an earlier character, so compare first
      if (m_tvalid_i && m_tready_i) check_packet_byte(m_tdata_i, m_tlast_i, m_tuser_i);
      if (s_tvalid_i && s_tready_i) predict_packet_bytes(s_tdata_i, s_tlast_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegTransactionId: regs.transaction_id = cfg_data_i;
          RegHeaderFlags:   regs.header_flags   = cfg_data_i;
          RegQueryType:     regs.query_type     = cfg_data_i;
          RegQueryClass:    regs.query_class    = cfg_data_i;
          default: ;
        endcase
      end
      pending = expected_bytes.size();
    end
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the dns query builder
// ----------------------------------------------------------------------------
// Streams domain names into the block one character per transaction:
// first a few hand-picked names (empty labels, trailing dot, lone dot,
// extreme characters), then random names with random label lengths,
// some of them past the label limit, mixed with random character noise.
// The run steps through four phases of idling and stalling with different
// register settings. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import dqb_pkg::*;

  localparam int unsigned MaxLabel      = MaxLabelDef;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned EndCycles     = 64;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned TimeoutCycles = 1_000_000;
  // no register lives here, a write must be ignored
  localparam logic [CfgIdxW-1:0] RegNone = 8'hFF;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int          fail_count;
  int          pending_bytes;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  dns_query_builder_core #(
    .MAX_LABEL(MaxLabel)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  dqb_stream_checker #(
    .MAX_LABEL(MaxLabel)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .m_tuser_i   (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending_bytes),
    .fail_count_o(fail_count)
  );

  // valid stays high into the next character unless an idle gap is drawn
  task automatic send_char(input logic [7:0] ch, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending_bytes == 0);
    // a plain character gives no byte but may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input cfg_t val);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] dat [5];
    idx = '{RegNone, RegTransactionId, RegHeaderFlags, RegQueryType, RegQueryClass};
    dat = '{16'($urandom), val.transaction_id, val.header_flags, val.query_type,
            val.query_class};
    for (int k = 0; k < 5; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= dat[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_name(input bit force_long);
    logic [7:0]  chars[$];
    logic [7:0]  c;
    int unsigned n_labels;
    int unsigned len;
    int unsigned pick;
    n_labels = $urandom_range(4, 1);
    for (int l = 0; l < n_labels; l++) begin
      pick = $urandom_range(99);
      if (force_long && l == 0) len = MaxLabel + 3;
      else if (pick < 8) len = 0;
      else if (pick < 16) len = $urandom_range(MaxLabel + 8, MaxLabel - 2);
      else len = $urandom_range(12, 1);
      repeat (len) begin
        do c = 8'($urandom_range(255)); while (c == DotChar);
        chars.push_back(c);
      end
      // separator, or sometimes a trailing dot after the last label
      if (l < n_labels - 1 || $urandom_range(99) < 15) chars.push_back(DotChar);
    end
    if (chars.size() == 0) chars.push_back(DotChar);
    foreach (chars[k]) send_char(chars[k], k == chars.size() - 1);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(6, 1);
    repeat (n) send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned target, input bit lead_long);
    bit force_long;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    force_long     = lead_long;
    while (items_sent < target) begin
      if (force_long || $urandom_range(99) < 80) send_name(force_long);
      else send_noise();
      force_long = 1'b0;
      if ($urandom_range(29) == 0) pause_until_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_regs('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    // lone dot
    send_char(DotChar, 1'b1);
    // leading dot
    send_char(DotChar, 1'b0);
    send_char("a", 1'b1);
    // two dots in a row
    send_char("x", 1'b0);
    send_char(DotChar, 1'b0);
    send_char(DotChar, 1'b0);
    send_char("y", 1'b1);
    // trailing dot
    send_char("b", 1'b0);
    send_char(DotChar, 1'b1);
    // extreme character codes
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char("z", 1'b1);
    run_phase(0, 0, ItemsPerPhase, 1'b1);

    pause_until_drained();
    program_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_phase(87, 0, 2 * ItemsPerPhase, 1'b0);

    pause_until_drained();
    program_regs('{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
    run_phase(0, 87, 3 * ItemsPerPhase, 1'b0);

    pause_until_drained();
    program_regs('{16'($urandom), HeaderFlagsRst, 16'd28, QueryClassRst});
    run_phase(38, 38, 4 * ItemsPerPhase, 1'b0);

    pause_until_drained();
    repeat (EndCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
hdl/dqb_pkg.sv
hdl/dqb_label_ram.sv
hdl/dqb_cfg_regs.sv
hdl/dqb_ctrl.sv
hdl/dns_query_builder_core.sv
dv/dqb_stream_checker.sv
dv/testbench.sv
